// ===== hw/rtl/gcd_pkg.sv =====
package gcd_pkg;

    localparam int CW       = 34;
    localparam int STEP_CAP = 40;

    typedef logic signed [CW-1:0] cw_t;

    localparam cw_t PI_Q30      = 34'sd3373259426;
    localparam cw_t HALF_PI_Q30 = 34'sd1686629713;

    localparam logic signed [32:0] DEG_HALF = 33'sd754974720;
    localparam logic signed [32:0] DEG_FULL = 33'sd1509949440;

    localparam logic [34:0] RAD_PER_DEG_Q40 = 35'd19190098068;
    localparam logic [26:0] RADIUS_X16      = 27'd101936000;
    localparam logic [28:0] DIST_MAX        = 29'd320241392;

    localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

    // atan(2^-i) in Q30, rounded
    function automatic cw_t atan_q30(input int i);
        cw_t r;
        case (i)
            0:       r = 34'sd843314857;
            1:       r = 34'sd497837829;
            2:       r = 34'sd263043837;
            3:       r = 34'sd133525159;
            4:       r = 34'sd67021687;
            5:       r = 34'sd33543516;
            6:       r = 34'sd16775851;
            7:       r = 34'sd8388437;
            8:       r = 34'sd4194283;
            9:       r = 34'sd2097149;
            default: r = (i <= 30) ? (cw_t'(1) <<< (30 - i)) : ((i == 31) ? cw_t'(1) : '0);
        endcase
        return r;
    endfunction

    // restoring long division, elaboration time only
    function automatic longint unsigned quot64(input longint unsigned n,
                                               input longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        int              b;
        q = 64'd0;
        r = 64'd0;
        for (b = 63; b >= 0; b--)
        begin
            r = (r << 1) | ((n >> b) & 64'd1);
            if (r >= d)
            begin
                r = r - d;
                q = q | (64'd1 << b);
            end
        end
        return q;
    endfunction

    // floor(sqrt(prod 1/(1+2^-2i))) in Q30
    function automatic cw_t cordic_gain(input int n);
        longint unsigned v;
        longint unsigned r;
        longint unsigned bt;
        int              i;
        v = 64'd1 << 60;
        for (i = 0; i < n; i++)
        begin
            if (2 * i < 62)
            begin
                v = v - quot64(v, (64'd1 << (2 * i)) + 64'd1);
            end
        end
        r  = 64'd0;
        bt = 64'd1 << 62;
        for (i = 0; i < 32; i++)
        begin
            if (v >= r + bt)
            begin
                v = v - (r + bt);
                r = (r >> 1) + bt;
            end
            else
            begin
                r = r >> 1;
            end
            bt = bt >> 2;
        end
        return cw_t'(r);
    endfunction

endpackage

// ===== hw/rtl/gcd_rad.sv =====
module gcd_rad import gcd_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               vld_in,
    input  logic signed [32:0] deg,
    output logic               vld_out,
    output cw_t                rad
);

    logic signed [32:0] red_next;
    logic signed [32:0] mag_next;
    logic [29:0]        mag_reg;
    logic               neg0_reg;
    logic [46:0]        plo_reg;
    logic [47:0]        phi_reg;
    logic               neg1_reg;
    logic [64:0]        sum;
    logic [31:0]        q;
    cw_t                rad_next;
    cw_t                rad_reg;
    logic [2:0]         vld_reg;

    always_comb
    begin
        if (deg > DEG_HALF)
        begin
            red_next = deg - DEG_FULL;
        end
        else if (deg <= -DEG_HALF)
        begin
            red_next = deg + DEG_FULL;
        end
        else
        begin
            red_next = deg;
        end
        mag_next = red_next[32] ? -red_next : red_next;
    end

    always_comb
    begin
        sum      = {phi_reg, 17'd0} + 65'(plo_reg) + (65'd1 << 31);
        q        = sum[63:32];
        rad_next = neg1_reg ? -cw_t'({2'b00, q}) : cw_t'({2'b00, q});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[1:0], vld_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg  <= mag_next[29:0];
            neg0_reg <= red_next[32];
            plo_reg  <= 47'(mag_reg) * 47'(RAD_PER_DEG_Q40[16:0]);
            phi_reg  <= 48'(mag_reg) * 48'(RAD_PER_DEG_Q40[34:17]);
            neg1_reg <= neg0_reg;
            rad_reg  <= rad_next;
        end
    end

    assign vld_out = vld_reg[2];
    assign rad     = rad_reg;

endmodule

// ===== hw/rtl/gcd_rot.sv =====
module gcd_rot import gcd_pkg::*; #(
    parameter int STEPS = 24
) (
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic vld_in,
    input  cw_t  z,
    output logic vld_out,
    output cw_t  sine,
    output cw_t  cosine
);

    localparam cw_t GAIN = cordic_gain(STEPS);

    cw_t  x_reg [0:STEPS];
    cw_t  y_reg [0:STEPS];
    cw_t  z_reg [0:STEPS];
    logic neg_reg [0:STEPS];
    cw_t  x_next [0:STEPS-1];
    cw_t  y_next [0:STEPS-1];
    cw_t  z_next [0:STEPS-1];
    logic [STEPS+1:0] vld_reg;
    cw_t  z0_next;
    logic neg0_next;
    cw_t  sine_reg;
    cw_t  cosine_reg;

    always_comb
    begin
        if (z > HALF_PI_Q30)
        begin
            z0_next   = z - PI_Q30;
            neg0_next = 1'b1;
        end
        else if (z < -HALF_PI_Q30)
        begin
            z0_next   = z + PI_Q30;
            neg0_next = 1'b1;
        end
        else
        begin
            z0_next   = z;
            neg0_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[STEPS:0], vld_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]   <= GAIN;
            y_reg[0]   <= '0;
            z_reg[0]   <= z0_next;
            neg_reg[0] <= neg0_next;
            sine_reg   <= neg_reg[STEPS] ? -y_reg[STEPS] : y_reg[STEPS];
            cosine_reg <= neg_reg[STEPS] ? -x_reg[STEPS] : x_reg[STEPS];
        end
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        localparam cw_t ANG = atan_q30(i);

        always_comb
        begin
            if (z_reg[i] >= 0)
            begin
                x_next[i] = x_reg[i] - (y_reg[i] >>> i);
                y_next[i] = y_reg[i] + (x_reg[i] >>> i);
                z_next[i] = z_reg[i] - ANG;
            end
            else
            begin
                x_next[i] = x_reg[i] + (y_reg[i] >>> i);
                y_next[i] = y_reg[i] - (x_reg[i] >>> i);
                z_next[i] = z_reg[i] + ANG;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i+1]   <= x_next[i];
                y_reg[i+1]   <= y_next[i];
                z_reg[i+1]   <= z_next[i];
                neg_reg[i+1] <= neg_reg[i];
            end
        end
    end

    assign vld_out = vld_reg[STEPS+1];
    assign sine    = sine_reg;
    assign cosine  = cosine_reg;

endmodule

// ===== hw/rtl/gcd_acos.sv =====
module gcd_acos import gcd_pkg::*; #(
    parameter int STEPS = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               vld_in,
    input  logic signed [31:0] c,
    output logic               vld_out,
    output cw_t                ang
);

    localparam int SQ = 31;

    logic signed [63:0] csq_full;
    logic [61:0]        csq_reg;
    logic signed [31:0] ca_reg;
    logic               va_reg;

    logic [61:0]        rem_reg  [0:SQ];
    logic [61:0]        root_reg [0:SQ];
    logic signed [31:0] cs_reg   [0:SQ];
    logic [61:0]        rem_next [0:SQ-1];
    logic [61:0]        root_next[0:SQ-1];
    logic [SQ:0]        vs_reg;

    cw_t  vx_reg [0:STEPS];
    cw_t  vy_reg [0:STEPS];
    cw_t  vz_reg [0:STEPS];
    cw_t  vx_next[0:STEPS-1];
    cw_t  vy_next[0:STEPS-1];
    cw_t  vz_next[0:STEPS-1];
    logic [STEPS:0] vv_reg;

    cw_t s_init;
    cw_t c_init;

    assign csq_full = c * c;
    assign s_init   = cw_t'({1'b0, root_reg[SQ][30:0]});
    assign c_init   = cw_t'(cs_reg[SQ]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vs_reg <= '0;
            vv_reg <= '0;
        end
        else if (en)
        begin
            va_reg <= vld_in;
            vs_reg <= {vs_reg[SQ-1:0], va_reg};
            vv_reg <= {vv_reg[STEPS-1:0], vs_reg[SQ]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            csq_reg     <= csq_full[61:0];
            ca_reg      <= c;
            rem_reg[0]  <= (62'd1 << 60) - csq_reg;
            root_reg[0] <= '0;
            cs_reg[0]   <= ca_reg;
            if (cs_reg[SQ] < 0)
            begin
                vx_reg[0] <= s_init;
                vy_reg[0] <= -c_init;
                vz_reg[0] <= HALF_PI_Q30;
            end
            else
            begin
                vx_reg[0] <= c_init;
                vy_reg[0] <= s_init;
                vz_reg[0] <= '0;
            end
        end
    end

    for (genvar k = 0; k < SQ; k++)
    begin : g_sqrt
        localparam logic [61:0] BT = 62'd1 << (2 * (SQ - 1 - k));

        always_comb
        begin
            if (rem_reg[k] >= root_reg[k] + BT)
            begin
                rem_next[k]  = rem_reg[k] - (root_reg[k] + BT);
                root_next[k] = (root_reg[k] >> 1) + BT;
            end
            else
            begin
                rem_next[k]  = rem_reg[k];
                root_next[k] = root_reg[k] >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= rem_next[k];
                root_reg[k+1] <= root_next[k];
                cs_reg[k+1]   <= cs_reg[k];
            end
        end
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_vec
        localparam cw_t ANG = atan_q30(i);

        always_comb
        begin
            if (vy_reg[i] >= 0)
            begin
                vx_next[i] = vx_reg[i] + (vy_reg[i] >>> i);
                vy_next[i] = vy_reg[i] - (vx_reg[i] >>> i);
                vz_next[i] = vz_reg[i] + ANG;
            end
            else
            begin
                vx_next[i] = vx_reg[i] - (vy_reg[i] >>> i);
                vy_next[i] = vy_reg[i] + (vx_reg[i] >>> i);
                vz_next[i] = vz_reg[i] - ANG;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                vx_reg[i+1] <= vx_next[i];
                vy_reg[i+1] <= vy_next[i];
                vz_reg[i+1] <= vz_next[i];
            end
        end
    end

    assign vld_out = vv_reg[STEPS];
    assign ang     = vz_reg[STEPS];

endmodule

// ===== hw/rtl/great_circle_distance.sv =====
// Channel  Handshake             Payload
// in       in_valid / in_ready   lat_a, lon_a, lat_b, lon_b (degrees, Q22)
// out      out_valid / out_ready distance (1/16 m)
//
// One word enters per cycle unless the output stalls; the pipeline depth is set
// by the rotation and vectoring CORDIC chains and the 31-stage square root.
// rst_n clears all valid bits; payload registers are not reset.
// A stalled output holds the whole pipeline; in_ready = !out_valid || out_ready.
module great_circle_distance import gcd_pkg::*; #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [29:0] lat_a,
    input  logic signed [30:0] lon_a,
    input  logic signed [29:0] lat_b,
    input  logic signed [30:0] lon_b,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [28:0]        distance
);

    localparam int NSTEPS = (CORDIC_STEPS < 1) ? 1 :
                            ((CORDIC_STEPS > STEP_CAP) ? STEP_CAP : CORDIC_STEPS);

    logic               en;
    logic               vld_in;
    logic signed [32:0] dlon;
    logic               vld_ra, vld_rb, vld_rd;
    cw_t                rad_a, rad_b, rad_d;
    logic               vld_sa, vld_sb, vld_d;
    cw_t                sa, ca, sb, cb, sd, cd;

    logic signed [67:0] pab_reg;
    logic signed [67:0] pss1_reg;
    cw_t                cd1_reg;
    logic signed [67:0] tr;
    cw_t                t_reg;
    logic signed [67:0] pss2_reg;
    cw_t                cd2_reg;
    logic signed [67:0] p2_reg;
    logic signed [67:0] pss3_reg;
    logic signed [68:0] csum;
    logic signed [38:0] cq;
    logic signed [31:0] c_next;
    logic signed [31:0] c_reg;
    logic [3:0]         vp_reg;

    logic               vld_ang;
    cw_t                ang;
    logic [60:0]        prod_reg;
    logic               vd_reg;
    logic [60:0]        dsum;
    logic [30:0]        dq;
    logic [28:0]        dist_next;
    logic [28:0]        distance_reg;
    logic               out_valid_reg;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;
    assign vld_in   = in_valid && in_ready;
    assign dlon     = 33'(lon_a) - 33'(lon_b);

    gcd_rad u_rad_a (
        .clk(clk), .rst_n(rst_n), .en(en), .vld_in(vld_in),
        .deg(33'(lat_a)), .vld_out(vld_ra), .rad(rad_a)
    );

    gcd_rad u_rad_b (
        .clk(clk), .rst_n(rst_n), .en(en), .vld_in(vld_in),
        .deg(33'(lat_b)), .vld_out(vld_rb), .rad(rad_b)
    );

    gcd_rad u_rad_d (
        .clk(clk), .rst_n(rst_n), .en(en), .vld_in(vld_in),
        .deg(dlon), .vld_out(vld_rd), .rad(rad_d)
    );

    gcd_rot #(.STEPS(NSTEPS)) u_rot_a (
        .clk(clk), .rst_n(rst_n), .en(en), .vld_in(vld_ra), .z(rad_a),
        .vld_out(vld_sa), .sine(sa), .cosine(ca)
    );

    gcd_rot #(.STEPS(NSTEPS)) u_rot_b (
        .clk(clk), .rst_n(rst_n), .en(en), .vld_in(vld_rb), .z(rad_b),
        .vld_out(vld_sb), .sine(sb), .cosine(cb)
    );

    gcd_rot #(.STEPS(NSTEPS)) u_rot_d (
        .clk(clk), .rst_n(rst_n), .en(en), .vld_in(vld_rd), .z(rad_d),
        .vld_out(vld_d), .sine(sd), .cosine(cd)
    );

    always_comb
    begin
        tr   = pab_reg + 68'sd536870912;
        csum = 69'(pss3_reg) + 69'(p2_reg) + 69'sd536870912;
        cq   = csum[68:30];
        if (cq > 39'(ONE_Q30))
        begin
            c_next = ONE_Q30;
        end
        else if (cq < -39'(ONE_Q30))
        begin
            c_next = -ONE_Q30;
        end
        else
        begin
            c_next = cq[31:0];
        end
    end

    gcd_acos #(.STEPS(NSTEPS)) u_acos (
        .clk(clk), .rst_n(rst_n), .en(en), .vld_in(vp_reg[3]), .c(c_reg),
        .vld_out(vld_ang), .ang(ang)
    );

    always_comb
    begin
        dsum = prod_reg + (61'd1 << 29);
        dq   = dsum[60:30];
        dist_next = (dq > 31'(DIST_MAX)) ? DIST_MAX : dq[28:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_reg        <= '0;
            vd_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vp_reg        <= {vp_reg[2:0], vld_sa};
            vd_reg        <= vld_ang;
            out_valid_reg <= vd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pab_reg      <= 68'(ca) * 68'(cb);
            pss1_reg     <= 68'(sa) * 68'(sb);
            cd1_reg      <= cd;
            t_reg        <= cw_t'(tr >>> 30);
            pss2_reg     <= pss1_reg;
            cd2_reg      <= cd1_reg;
            p2_reg       <= 68'(t_reg) * 68'(cd2_reg);
            pss3_reg     <= pss2_reg;
            c_reg        <= c_next;
            prod_reg     <= ang[CW-1] ? '0 : 61'(ang[CW-2:0]) * 61'(RADIUS_X16);
            distance_reg <= dist_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign distance  = distance_reg;

    a_dist_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> distance <= DIST_MAX)
        else $error("distance above saturation bound");

    a_cos_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        vp_reg[3] |-> (c_reg <= ONE_Q30 && c_reg >= -ONE_Q30))
        else $error("cosine outside unit range");

    a_rot_align: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_ra == vld_rb) && (vld_rb == vld_rd) &&
        (vld_sa == vld_sb) && (vld_sb == vld_d))
        else $error("rotator pipelines out of step");

    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vp_reg) && $stable(c_reg))
        else $error("pipeline moved during stall");

endmodule

// ===== verif/gcd_checker.sv =====
`timescale 1ns / 100ps

module gcd_checker #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic signed [29:0] lat_a,
    input  logic signed [30:0] lon_a,
    input  logic signed [29:0] lat_b,
    input  logic signed [30:0] lon_b,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [28:0]        distance,
    output int                 errors,
    output int                 pending
);

    localparam int NSTEPS = (CORDIC_STEPS < 1) ? 1 :
                            ((CORDIC_STEPS > 40) ? 40 : CORDIC_STEPS);
    localparam longint DEG_HALF_D = 64'sd754974720;
    localparam longint DEG_FULL_D = 64'sd1509949440;
    localparam longint ONE        = 64'sd1 << 30;
    localparam longint HALF       = 64'sd1 << 29;
    localparam longint RADIUS16   = 64'sd101936000;
    localparam longint DMAX       = 64'sd320241392;

    longint         atan_rad [40];
    longint         pi_rad;
    longint         gain_k;
    longint unsigned deg_scale;
    logic [28:0]    dist_q [$];

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned r;
        longint unsigned bt;
        r  = 0;
        bt = 64'd1 << 62;
        while (bt > n)
            bt = bt >> 2;
        while (bt != 0)
        begin
            if (n >= r + bt)
            begin
                n = n - (r + bt);
                r = (r >> 1) + bt;
            end
            else
            begin
                r = r >> 1;
            end
            bt = bt >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned arctan_sum(input longint unsigned p, input int sh,
                                                   input longint unsigned dv);
        longint unsigned sum;
        longint unsigned t;
        longint unsigned k;
        sum = 0;
        k   = 0;
        while (p != 0)
        begin
            t = p / (2 * k + 1);
            if (k[0])
                sum = sum - t;
            else
                sum = sum + t;
            if (dv != 0)
                p = p / dv;
            else
                p = (sh < 64) ? (p >> sh) : 0;
            k++;
        end
        return sum;
    endfunction

    function automatic longint to_radians(input longint d);
        longint          r;
        longint unsigned mag;
        longint unsigned q;
        r = d % DEG_FULL_D;
        if (r > DEG_HALF_D)
            r = r - DEG_FULL_D;
        else if (r <= -DEG_HALF_D)
            r = r + DEG_FULL_D;
        mag = (r < 0) ? longint'(-r) : longint'(r);
        q   = (mag * deg_scale + (64'd1 << 31)) >> 32;
        return (r < 0) ? -longint'(q) : longint'(q);
    endfunction

    task automatic rotate(input longint z_in, output longint s, output longint c);
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        bit     flip;
        z    = z_in;
        x    = gain_k;
        y    = 0;
        flip = 0;
        if (z > (pi_rad >>> 1))
        begin
            z    = z - pi_rad;
            flip = 1;
        end
        else if (z < -(pi_rad >>> 1))
        begin
            z    = z + pi_rad;
            flip = 1;
        end
        for (int i = 0; i < NSTEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx; y = y + dy; z = z - atan_rad[i];
            end
            else
            begin
                x = x + dx; y = y - dy; z = z + atan_rad[i];
            end
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endtask

    function automatic longint central_angle(input longint c);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        longint s;
        s = longint'(int_sqrt(longint'(ONE * ONE - c * c)));
        x = c;
        y = s;
        z = 0;
        if (c < 0)
        begin
            x = s;
            y = -c;
            z = pi_rad >>> 1;
        end
        for (int i = 0; i < NSTEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x = x + dx; y = y - dy; z = z + atan_rad[i];
            end
            else
            begin
                x = x - dx; y = y + dy; z = z - atan_rad[i];
            end
        end
        return z;
    endfunction

    task automatic predict_distance(input longint la, input longint oa, input longint lb,
                                    input longint ob, output logic [28:0] d);
        longint sa, ca, sb, cb, sd, cd, p2, c, ang, dist_v;
        rotate(to_radians(la), sa, ca);
        rotate(to_radians(lb), sb, cb);
        rotate(to_radians(oa - ob), sd, cd);
        p2 = ((ca * cb + HALF) >>> 30) * cd;
        c  = (sa * sb + p2 + HALF) >>> 30;
        if (c > ONE)
            c = ONE;
        if (c < -ONE)
            c = -ONE;
        ang = central_angle(c);
        if (ang < 0)
            ang = 0;
        dist_v = (ang * RADIUS16 + HALF) >>> 30;
        if (dist_v > DMAX)
            dist_v = DMAX;
        d = dist_v[28:0];
    endtask

    initial
    begin
        longint unsigned quarter;
        longint unsigned v;
        quarter = 4 * arctan_sum((64'd1 << 60) / 5, 0, 25)
                  - arctan_sum((64'd1 << 60) / 239, 0, 57121);
        pi_rad      = longint'((4 * quarter + (64'd1 << 29)) >> 30);
        atan_rad[0] = longint'((quarter + (64'd1 << 29)) >> 30);
        for (int i = 1; i < 40; i++)
            atan_rad[i] = longint'((arctan_sum(64'd1 << (60 - i), 2 * i, 0)
                                    + (64'd1 << 29)) >> 30);
        v = 64'd1 << 60;
        for (int i = 0; i < NSTEPS; i++)
            if (2 * i < 62)
                v = v - v / ((64'd1 << (2 * i)) + 1);
        gain_k    = longint'(int_sqrt(v));
        deg_scale = (64'd6283185307 * (64'd1 << 29) + 64'd87890625) / 64'd175781250;
    end

    always @(posedge clk)
    begin
        logic [28:0] want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                predict_distance(lat_a, lon_a, lat_b, lon_b, want);
                dist_q.push_back(want);
            end
            if (out_valid && out_ready)
            begin
                if (dist_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected word: distance %0d", distance);
                end
                else
                begin
                    want = dist_q.pop_front();
                    if (distance !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("distance mismatch: expected %0d actual %0d",
                                     want, distance);
                    end
                end
            end
            pending = dist_q.size();
        end
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam int  CORDIC_STEPS = 24;
    localparam int  LAT_MAX = 377487360;
    localparam int  LON_MAX = 754974720;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [29:0] lat_a;
    logic signed [30:0] lon_a;
    logic signed [29:0] lat_b;
    logic signed [30:0] lon_b;
    logic               out_valid;
    logic               out_ready;
    logic [28:0]        distance;
    int                 errors;
    int                 pending;
    int                 send_idle;
    int                 recv_stall;

    great_circle_distance #(.CORDIC_STEPS(CORDIC_STEPS)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .lat_a(lat_a), .lon_a(lon_a), .lat_b(lat_b), .lon_b(lon_b),
        .out_valid(out_valid), .out_ready(out_ready), .distance(distance)
    );

    gcd_checker #(.CORDIC_STEPS(CORDIC_STEPS)) checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .lat_a(lat_a), .lon_a(lon_a), .lat_b(lat_b), .lon_b(lon_b),
        .out_valid(out_valid), .out_ready(out_ready), .distance(distance),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("tb_top failed");
        $finish;
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall);

    task automatic send_word(input int la, input int oa, input int lb, input int ob);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        lat_a    <= la[29:0];
        lon_a    <= oa[30:0];
        lat_b    <= lb[29:0];
        lon_b    <= ob[30:0];
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    function automatic int rand_in(input int lim);
        return $signed($urandom_range(2 * lim)) - lim;
    endfunction

    task automatic send_random();
        int la, oa, lb, ob, k;
        k  = $urandom_range(9);
        la = rand_in(LAT_MAX);
        oa = rand_in(LON_MAX);
        lb = rand_in(LAT_MAX);
        ob = rand_in(LON_MAX);
        case (k)
            0:
            begin
                la = $urandom; oa = $urandom; lb = $urandom; ob = $urandom;
            end
            1:
            begin
                lb = la + rand_in(4096);
                ob = oa + rand_in(4096);
            end
            2:
            begin
                lb = -la;
                ob = oa + ((oa > 0) ? -LON_MAX : LON_MAX) + rand_in(64);
            end
            3:
            begin
                lb = la;
                ob = oa;
            end
            default: ;
        endcase
        send_word(la, oa, lb, ob);
    endtask

    initial
    begin
        in_valid   = 0;
        lat_a      = '0;
        lon_a      = '0;
        lat_b      = '0;
        lon_b      = '0;
        send_idle  = 0;
        recv_stall = 0;
        rst_n      = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(0, 0, 0, 0);
        send_word(0, 0, 0, LON_MAX);
        send_word(0, LON_MAX, 0, -LON_MAX);
        send_word(LAT_MAX, 0, -LAT_MAX, 0);
        send_word(LAT_MAX, 123, LAT_MAX, -98765);
        send_word(-LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX);
        send_word(-LAT_MAX, -LON_MAX, -LAT_MAX, LON_MAX);
        send_word(32'h1fff_ffff, 32'h3fff_ffff, 32'hE000_0000, 32'hC000_0000);
        send_word(32'hE000_0000, 32'hC000_0000, 32'h1fff_ffff, 32'h3fff_ffff);
        send_word(32'h1fff_ffff, 32'hC000_0000, 32'h1fff_ffff, 32'h3fff_ffff);
        send_word(LAT_MAX / 2, LON_MAX / 2, -LAT_MAX / 2, -LON_MAX / 2);
        send_word(1, 1, -1, -1);
        send_word(0, 1, 0, 0);
        send_word(LAT_MAX - 1, LON_MAX, -LAT_MAX + 1, 0);
        send_word(0, LON_MAX + 1, 0, 0);
        send_word(0, -LON_MAX - 1, 0, 1);
        send_word(200000000, 300000000, -200000000, 300000000 - LON_MAX);
        send_word(-1, -1, -1, -1);

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle  = (ph == 1 || ph == 3) ? ((ph == 1) ? 77 : 19) : 0;
            recv_stall = (ph == 2 || ph == 3) ? ((ph == 2) ? 77 : 19) : 0;
            for (int n = 0; n < 185; n++)
                send_random();
        end
        in_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
